// ===== design/signed_decimal_field_formatter_core_assert.svh =====
// Assertion macros shared by the signed decimal formatter RTL.
`ifndef SIGNED_DECIMAL_FIELD_FORMATTER_CORE_ASSERT_SVH
`define SIGNED_DECIMAL_FIELD_FORMATTER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SDF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdf assertion failed");
`define SDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdf assertion failed");
`else
`define SDF_ASSERT_IMP(lbl, ante, cons)
`define SDF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/sdf_pkg.sv =====
// Types and constants of the signed decimal field formatter.
package sdf_pkg;

  localparam int VAL_W  = 64;
  localparam int NDIG   = 20;
  localparam int BCD_W  = 4 * NDIG;
  localparam int NDIG_W = $clog2(NDIG + 1);
  localparam int CNT_W  = $clog2(VAL_W + 1);

  localparam logic [2:0] SZ_INT   = 3'd0;
  localparam logic [2:0] SZ_SHORT = 3'd1;
  localparam logic [2:0] SZ_CHAR  = 3'd2;

  localparam int FL_PLUS  = 0;
  localparam int FL_SPACE = 1;
  localparam int FL_LEFT  = 2;
  localparam int FL_ZERO  = 3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [3:0] CH_DIGIT_HI = 4'h3;

  typedef struct packed {
    logic start;
    logic pop;
  } bcd_ctrl_t;

  typedef struct packed {
    logic              done;
    logic [NDIG_W-1:0] ndig;
    logic [3:0]        digit;
  } bcd_stat_t;

endpackage

// ===== design/sdf_bcd.sv =====
// Iterative binary to BCD converter (shift and add 3) with digit pop-out.
`include "signed_decimal_field_formatter_core_assert.svh"
module sdf_bcd (
  input  logic                         clk,
  input  logic                         rst,
  input  sdf_pkg::bcd_ctrl_t           ctrl,
  input  logic [sdf_pkg::VAL_W-1:0]    mag,
  output sdf_pkg::bcd_stat_t           stat
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SHIFT = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } bcd_state_t;

  bcd_state_t                    state;
  logic [sdf_pkg::VAL_W-1:0]     bin;
  logic [sdf_pkg::BCD_W-1:0]     bcd;
  logic [sdf_pkg::BCD_W-1:0]     adj;
  logic [sdf_pkg::CNT_W-1:0]     cnt;
  logic [sdf_pkg::NDIG_W-1:0]    ndig;
  logic [3:0]                    top_nib;

  assign top_nib = bcd[sdf_pkg::BCD_W-1 -: 4];

  always_comb begin
    for (int i = 0; i < sdf_pkg::NDIG; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (ctrl.start) begin
      bin   <= mag;
      bcd   <= '0;
      cnt   <= sdf_pkg::CNT_W'(sdf_pkg::VAL_W);
      ndig  <= sdf_pkg::NDIG_W'(sdf_pkg::NDIG);
      state <= ST_SHIFT;
    end else begin
      case (state)
        ST_IDLE: begin
        end
        ST_SHIFT: begin
          {bcd, bin} <= {adj[sdf_pkg::BCD_W-2:0], bin, 1'b0};
          cnt <= cnt - 1'b1;
          if (cnt == sdf_pkg::CNT_W'(1)) state <= ST_SCAN;
        end
        ST_SCAN: begin
          // strip leading zeros, keep at least one digit
          if (top_nib == 4'd0 && ndig > sdf_pkg::NDIG_W'(1)) begin
            bcd  <= {bcd[sdf_pkg::BCD_W-5:0], 4'h0};
            ndig <= ndig - 1'b1;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (ctrl.pop) bcd <= {bcd[sdf_pkg::BCD_W-5:0], 4'h0};
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    stat.done  = (state == ST_DONE);
    stat.ndig  = ndig;
    stat.digit = top_nib;
  end

  `SDF_ASSERT_IMP(a_start_not_busy, ctrl.start, (state != ST_SHIFT) && (state != ST_SCAN))
  `SDF_ASSERT_IMP(a_ndig_range, state == ST_DONE, (ndig != '0) && (ndig <= sdf_pkg::NDIG_W'(sdf_pkg::NDIG)))
  `SDF_ASSERT_IMP(a_pop_when_done, ctrl.pop, state == ST_DONE)

endmodule

// ===== design/signed_decimal_field_formatter_core.sv =====
// Signed decimal field formatter: one request in, a padded ASCII field out, one char per transfer.
// Each request narrows the argument by size_mode, takes its magnitude and converts it to BCD in a
// shift-and-add-3 unit, which then strips up to 19 leading zeros. The field is then sized, and
// characters leave one per cycle while char_ready is high, N = max(width, digits + sign) of them.
// The ready output is high only between requests. Width is saturated to MAX_WIDTH.
`include "signed_decimal_field_formatter_core_assert.svh"
module signed_decimal_field_formatter_core #(
  parameter int MAX_WIDTH = 63
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               ready,
  input  logic signed [63:0] value,
  input  logic [2:0]         size_mode,
  input  logic [5:0]         width,
  input  logic [3:0]         flag_bits,
  output logic               char_valid,
  input  logic               char_ready,
  output logic [7:0]         char_code,
  output logic               last
);

  localparam int PW      = $clog2(MAX_WIDTH + 1);
  localparam int MAX_LEN = (MAX_WIDTH > sdf_pkg::NDIG + 1) ? MAX_WIDTH : sdf_pkg::NDIG + 1;
  localparam int RW      = $clog2(MAX_LEN + 1);
  localparam int WXW     = (PW > 6) ? PW : 6;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CONV  = 7'b0000010,
    S_LEAD  = 7'b0000100,
    S_SIGN  = 7'b0001000,
    S_ZERO  = 7'b0010000,
    S_DIG   = 7'b0100000,
    S_TRAIL = 7'b1000000
  } fmt_state_t;

  fmt_state_t                   state;
  sdf_pkg::bcd_ctrl_t           ctrl;
  sdf_pkg::bcd_stat_t           stat;

  logic [sdf_pkg::VAL_W-1:0]    narrowed;
  logic [sdf_pkg::VAL_W-1:0]    mag_in;
  logic [WXW-1:0]               w_ext;
  logic [WXW-1:0]               w_sat;

  logic [PW-1:0]                wsat;
  logic                         has_sign;
  logic [7:0]                   sign_char;
  logic                         lead_en;
  logic                         zero_en;
  logic                         left_en;
  logic [RW-1:0]                pad_q;
  logic [RW-1:0]                remain;
  logic [sdf_pkg::NDIG_W-1:0]   dleft;

  logic [RW-1:0]                len_v;
  logic [RW-1:0]                wid_v;
  logic [RW-1:0]                pad_v;
  logic                         emitting;
  logic                         emit;
  logic [7:0]                   ch;

  always_comb begin
    case (size_mode)
      sdf_pkg::SZ_INT:   narrowed = {{32{value[31]}}, value[31:0]};
      sdf_pkg::SZ_SHORT: narrowed = {{48{value[15]}}, value[15:0]};
      sdf_pkg::SZ_CHAR:  narrowed = {{56{value[7]}}, value[7:0]};
      default:           narrowed = value;
    endcase
    // most negative value wraps to itself, which reads correctly as unsigned
    mag_in = narrowed[63] ? (~narrowed + 64'd1) : narrowed;
    w_ext  = WXW'(width);
    w_sat  = (w_ext > WXW'(MAX_WIDTH)) ? WXW'(MAX_WIDTH) : w_ext;
  end

  assign ready     = (state == S_IDLE);
  assign ctrl.start = valid && ready;
  assign ctrl.pop   = emit && (state == S_DIG);

  sdf_bcd u_bcd (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .mag  (mag_in),
    .stat (stat)
  );

  always_comb begin
    len_v = RW'(stat.ndig) + RW'(has_sign);
    wid_v = RW'(wsat);
    pad_v = (wid_v > len_v) ? wid_v - len_v : '0;
  end

  assign emitting = (state == S_LEAD) || (state == S_SIGN) || (state == S_ZERO) ||
                    (state == S_DIG) || (state == S_TRAIL);
  assign emit = emitting && (!char_valid || char_ready);

  always_comb begin
    case (state)
      S_SIGN:  ch = sign_char;
      S_ZERO:  ch = {sdf_pkg::CH_DIGIT_HI, 4'h0};
      S_DIG:   ch = {sdf_pkg::CH_DIGIT_HI, stat.digit};
      default: ch = sdf_pkg::CH_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      char_valid <= 1'b0;
    end else begin
      if (emit) begin
        char_valid <= 1'b1;
        char_code  <= ch;
        last       <= (remain == RW'(1));
        remain     <= remain - 1'b1;
      end else if (char_ready) begin
        char_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (valid) begin
            wsat      <= PW'(w_sat);
            has_sign  <= narrowed[63] || flag_bits[sdf_pkg::FL_PLUS] ||
                         flag_bits[sdf_pkg::FL_SPACE];
            sign_char <= narrowed[63] ? sdf_pkg::CH_MINUS :
                         flag_bits[sdf_pkg::FL_PLUS] ? sdf_pkg::CH_PLUS : sdf_pkg::CH_SPACE;
            left_en   <= flag_bits[sdf_pkg::FL_LEFT];
            zero_en   <= !flag_bits[sdf_pkg::FL_LEFT] && flag_bits[sdf_pkg::FL_ZERO];
            lead_en   <= !flag_bits[sdf_pkg::FL_LEFT] && !flag_bits[sdf_pkg::FL_ZERO];
            state     <= S_CONV;
          end
        end
        S_CONV: begin
          if (stat.done) begin
            pad_q  <= pad_v;
            remain <= pad_v + len_v;
            dleft  <= stat.ndig;
            if (lead_en && pad_v != '0)      state <= S_LEAD;
            else if (has_sign)               state <= S_SIGN;
            else if (zero_en && pad_v != '0) state <= S_ZERO;
            else                             state <= S_DIG;
          end
        end
        S_LEAD: begin
          if (emit) begin
            pad_q <= pad_q - 1'b1;
            if (pad_q == RW'(1)) state <= has_sign ? S_SIGN : S_DIG;
          end
        end
        S_SIGN: begin
          if (emit) state <= (zero_en && pad_q != '0) ? S_ZERO : S_DIG;
        end
        S_ZERO: begin
          if (emit) begin
            pad_q <= pad_q - 1'b1;
            if (pad_q == RW'(1)) state <= S_DIG;
          end
        end
        S_DIG: begin
          if (emit) begin
            dleft <= dleft - 1'b1;
            if (dleft == sdf_pkg::NDIG_W'(1)) begin
              state <= (left_en && pad_q != '0) ? S_TRAIL : S_IDLE;
            end
          end
        end
        S_TRAIL: begin
          if (emit) begin
            pad_q <= pad_q - 1'b1;
            if (pad_q == RW'(1)) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SDF_ASSERT_NEXT(a_last_to_idle, emit && (remain == RW'(1)), state == S_IDLE)
  `SDF_ASSERT_IMP(a_dig_converted, state == S_DIG, stat.done)
  `SDF_ASSERT_NEXT(a_req_starts_conv, valid && ready, state == S_CONV)

endmodule
